### rtl/core/bdc_pkg.sv
package bdc_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned DELAY_W  = 16;
   localparam int unsigned STATE_W  = 3;
   localparam int unsigned CSR_IDX_W = 3;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_MS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_MS    = 3'd4;

   // Classifier settings shared with the state machine
   typedef struct packed {
      logic               active_low;
      logic [DELAY_W-1:0] press_ms;
      logic [DELAY_W-1:0] click_ms;
   } cls_cfg_type;

   // Events recognized on one sample
   typedef struct packed {
      logic clicked;
      logic double_clicked;
      logic long_pressed;
      logic long_released;
   } event_type;

endpackage

### rtl/core/bdc_if.sv
interface bdc_req_if;
   logic                        valid;
   logic                        ready;
   logic                        raw_level;
   logic [bdc_pkg::TIME_W-1:0]  time_ms;

   modport source (output valid, output raw_level, output time_ms, input ready);
   modport sink   (input valid, input raw_level, input time_ms, output ready);
endinterface

interface bdc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         clicked;
   logic                         double_clicked;
   logic                         long_pressed;
   logic                         long_released;
   logic                         switched;
   logic                         any_event;
   logic                         stable_level;
   logic [bdc_pkg::STATE_W-1:0]  class_state;

   modport source (output valid, output clicked, output double_clicked,
                   output long_pressed, output long_released, output switched,
                   output any_event, output stable_level, output class_state,
                   input ready);
   modport sink   (input valid, input clicked, input double_clicked,
                   input long_pressed, input long_released, input switched,
                   input any_event, input stable_level, input class_state,
                   output ready);
endinterface

### rtl/core/bdc_debounce.sv
module bdc_debounce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          raw_level,
   input  logic [bdc_pkg::TIME_W-1:0]    now,
   input  logic [bdc_pkg::DELAY_W-1:0]   debounce_ms,
   output logic                          level_in
);

   logic                        prev_raw_ff;
   logic                        level_ff;
   logic [bdc_pkg::TIME_W-1:0]  change_time_ff;
   logic [bdc_pkg::TIME_W-1:0]  change_time_in;
   logic [bdc_pkg::TIME_W-1:0]  steady_time;

   // A changed sample restarts the timer, so its difference is zero and never passes
   assign change_time_in = (raw_level != prev_raw_ff) ? now : change_time_ff;
   assign steady_time    = now - change_time_in;
   assign level_in       = (steady_time > {{(bdc_pkg::TIME_W-bdc_pkg::DELAY_W){1'b0}},
                                           debounce_ms}) ? raw_level : level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff    <= 1'b0;
         level_ff       <= 1'b0;
         change_time_ff <= '0;
      end else if (advance) begin
         prev_raw_ff    <= raw_level;
         level_ff       <= level_in;
         change_time_ff <= change_time_in;
      end
   end

endmodule

### rtl/core/bdc_classifier.sv
module bdc_classifier (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          load_start,
   input  logic [bdc_pkg::STATE_W-1:0]   start_state,
   input  bdc_pkg::cls_cfg_type          cfg,
   input  logic                          level,
   input  logic [bdc_pkg::TIME_W-1:0]    now,
   output bdc_pkg::event_type            events,
   output logic [bdc_pkg::STATE_W-1:0]   state_code
);

   typedef enum logic [bdc_pkg::STATE_W-1:0] {
      ST_IDLE = 3'd0,
      ST_D    = 3'd1,
      ST_DU   = 3'd2,
      ST_DUD  = 3'd3,
      ST_HELD = 3'd4,
      ST_U    = 3'd5,
      ST_UD   = 3'd6,
      ST_UDU  = 3'd7
   } state_type;

   state_type                   state_ff;
   state_type                   state_in;
   logic [bdc_pkg::TIME_W-1:0]  phase_ff;
   logic [bdc_pkg::TIME_W-1:0]  phase_in;
   logic [bdc_pkg::TIME_W-1:0]  phase_age;
   logic                        pressed;
   logic                        press_over;
   logic                        click_over;

   assign pressed    = (level == !cfg.active_low);
   assign phase_age  = now - phase_ff;
   assign press_over = phase_age > {{(bdc_pkg::TIME_W-bdc_pkg::DELAY_W){1'b0}}, cfg.press_ms};
   assign click_over = phase_age > {{(bdc_pkg::TIME_W-bdc_pkg::DELAY_W){1'b0}}, cfg.click_ms};

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      events   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pressed) begin
               state_in = ST_D;
               phase_in = now;
            end
         end
         ST_D: begin
            priority if (!pressed) begin
               state_in = ST_DU;
               phase_in = now;
            end else if (press_over) begin
               events.long_pressed = 1'b1;
               state_in = ST_HELD;
            end else begin
               // hold state and phase
            end
         end
         ST_DU: begin
            priority if (click_over) begin
               events.clicked = 1'b1;
               state_in = ST_IDLE;
            end else if (pressed) begin
               state_in = ST_DUD;
               phase_in = now;
            end else begin
               // hold state and phase
            end
         end
         ST_DUD: begin
            priority if (click_over) begin
               events.double_clicked = 1'b1;
               state_in = ST_HELD;
            end else if (!pressed) begin
               events.double_clicked = 1'b1;
               state_in = ST_IDLE;
            end else begin
               // hold state and phase
            end
         end
         ST_HELD: begin
            if (!pressed) begin
               state_in = ST_U;
               phase_in = now;
            end
         end
         ST_U: begin
            priority if (pressed) begin
               state_in = ST_UD;
               phase_in = now;
            end else if (press_over) begin
               events.long_released = 1'b1;
               state_in = ST_IDLE;
            end else begin
               // hold state and phase
            end
         end
         ST_UD: begin
            priority if (click_over) begin
               events.clicked = 1'b1;
               state_in = ST_HELD;
            end else if (!pressed) begin
               state_in = ST_UDU;
               phase_in = now;
            end else begin
               // hold state and phase
            end
         end
         ST_UDU: begin
            priority if (click_over) begin
               events.double_clicked = 1'b1;
               state_in = ST_IDLE;
            end else if (pressed) begin
               events.double_clicked = 1'b1;
               state_in = ST_HELD;
            end else begin
               // hold state and phase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign state_code = state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         // start_state itself returns to idle at reset
         state_ff <= ST_IDLE;
         phase_ff <= '0;
      end else if (load_start) begin
         state_ff <= state_type'(start_state);
      end else if (advance) begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

### rtl/core/button_debounce_click_classifier.sv
// Channel  Dir  Handshake     Payload
// req_chan in   valid/ready   raw_level, time_ms
// rsp_chan out  valid/ready   event flags, switched, any_event, stable_level, class_state
// csr      in   csr_wr_en     csr_index, csr_wdata (no read-back)
//
// Each item yields exactly one result item; the block takes one item per cycle
// while the result side is not stalled. An item passes the input register, then
// debounce and classifier logic into the result register. The state loop closes at
// the result load. Reset is synchronous: valid flags, configuration and state
// registers return to their defaults and the classifier to idle, the start_state
// default. A stalled result holds in the result register while one more item waits
// in the input register; req_chan.ready drops only when both are full.
module button_debounce_click_classifier (
   input  logic                           clock,
   input  logic                           reset,
   bdc_req_if.sink                        req_chan,
   bdc_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [bdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bdc_pkg::DELAY_W-1:0]    csr_wdata
);

   // Configuration registers
   logic                          active_low_ff;
   logic [bdc_pkg::STATE_W-1:0]   start_state_ff;
   logic [bdc_pkg::DELAY_W-1:0]   debounce_ms_ff;
   logic [bdc_pkg::DELAY_W-1:0]   press_ms_ff;
   logic [bdc_pkg::DELAY_W-1:0]   click_ms_ff;
   logic                          load_start;

   // Input register
   logic                          in_vld_ff;
   logic                          in_raw_ff;
   logic [bdc_pkg::TIME_W-1:0]    in_time_ff;

   // Result register
   logic                          out_vld_ff;
   bdc_pkg::event_type            out_events_ff;
   logic                          out_level_ff;
   logic [bdc_pkg::STATE_W-1:0]   out_state_ff;

   logic                          advance;
   logic                          level_in;
   bdc_pkg::event_type            events_in;
   logic [bdc_pkg::STATE_W-1:0]   state_in;
   bdc_pkg::cls_cfg_type          cls_cfg;

   // Move the held item into the result register when that slot is free or draining
   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign load_start     = csr_wr_en && (csr_index == bdc_pkg::CSR_START_STATE);

   assign cls_cfg.active_low = active_low_ff;
   assign cls_cfg.press_ms   = press_ms_ff;
   assign cls_cfg.click_ms   = click_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff  <= 1'b1;
         start_state_ff <= '0;
         debounce_ms_ff <= bdc_pkg::DELAY_W'(50);
         press_ms_ff    <= bdc_pkg::DELAY_W'(1000);
         click_ms_ff    <= bdc_pkg::DELAY_W'(250);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bdc_pkg::CSR_ACTIVE_LOW:  active_low_ff  <= csr_wdata[0];
            bdc_pkg::CSR_START_STATE: start_state_ff <= csr_wdata[bdc_pkg::STATE_W-1:0];
            bdc_pkg::CSR_DEBOUNCE_MS: debounce_ms_ff <= csr_wdata;
            bdc_pkg::CSR_PRESS_MS:    press_ms_ff    <= csr_wdata;
            bdc_pkg::CSR_CLICK_MS:    click_ms_ff    <= csr_wdata;
            default: ; // unknown index: drop the write
         endcase
      end
   end

   // The classifier loads the written code directly, same edge as the register
   bdc_debounce u_debounce (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .raw_level   (in_raw_ff),
      .now         (in_time_ff),
      .debounce_ms (debounce_ms_ff),
      .level_in    (level_in)
   );

   bdc_classifier u_classifier (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .load_start  (load_start),
      .start_state ((csr_wr_en && load_start) ? csr_wdata[bdc_pkg::STATE_W-1:0]
                                               : start_state_ff),
      .cfg         (cls_cfg),
      .level       (level_in),
      .now         (in_time_ff),
      .events      (events_in),
      .state_code  (state_in)
   );

   // Input register: capture an accepted item, empty it once it advances
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_raw_ff  <= req_chan.raw_level;
         in_time_ff <= req_chan.time_ms;
      end
   end

   // Result register: hold while the sink stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_events_ff <= events_in;
         out_level_ff  <= level_in;
         out_state_ff  <= state_in;
      end
   end

   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.clicked        = out_events_ff.clicked;
   assign rsp_chan.double_clicked = out_events_ff.double_clicked;
   assign rsp_chan.long_pressed   = out_events_ff.long_pressed;
   assign rsp_chan.long_released  = out_events_ff.long_released;
   assign rsp_chan.switched       = out_events_ff.long_pressed | out_events_ff.long_released;
   assign rsp_chan.any_event      = |out_events_ff;
   assign rsp_chan.stable_level   = out_level_ff;
   assign rsp_chan.class_state    = out_state_ff;

   // An advancing item always lands in the result register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff)
      else $error("advanced item did not reach result register");

   // A transition never raises more than one event
   a_single_event: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> $onehot0(out_events_ff))
      else $error("more than one event flag in one result");

   // A held item that cannot advance blocks the input side
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |-> !req_chan.ready)
      else $error("input accepted while input register full");

   // A stalled result is neither dropped nor overwritten
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_chan.ready) |=> (out_vld_ff && $stable(out_state_ff)
                                           && $stable(out_events_ff)))
      else $error("stalled result changed");

endmodule
